[design/adws_pkg.sv]
// Shared types and constants for the adaptive dark window selector.
`timescale 1ns / 1ps

package adws_pkg;

	localparam int MAX_COLS = 1024;
	localparam int MAX_WIN  = 64;
	localparam int MAX_ROWS = 4096;

	localparam int COL_W   = $clog2(MAX_COLS);
	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int SLOT_W  = $clog2(MAX_WIN);
	localparam int LN_AW   = SLOT_W + COL_W;
	localparam int CS_W    = 14;
	localparam int WS_W    = 20;
	localparam int THR_W   = 27;
	localparam int CNT_W   = 23;
	localparam int RATIO_W = 7;
	localparam int AREA_W  = 20;
	localparam int NROWS_W = 13;
	localparam int NCOLS_W = 11;
	localparam int WIN_W   = 7;

	localparam logic [RATIO_W-1:0] RATIO_START = 7'd94;
	localparam logic [RATIO_W-1:0] RATIO_CAP   = 7'd99;
	localparam logic [RATIO_W-1:0] RATIO_FLOOR = 7'd75;
	localparam logic [CNT_W-1:0]   COUNT_MAX   = {CNT_W{1'b1}};

	typedef enum logic [2:0] {
		REG_ROWS   = 3'd0,
		REG_COLS   = 3'd1,
		REG_WIN_W  = 3'd2,
		REG_WIN_H  = 3'd3,
		REG_STRIDE = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_start;
	} in_t;

	typedef struct packed {
		logic               kind;
		logic [10:0]        centre_x;
		logic [12:0]        centre_y;
		logic [CNT_W-1:0]   count;
		logic [RATIO_W-1:0] ratio_pct;
		logic               last;
	} out_t;

	typedef struct packed {
		logic [SLOT_W-1:0] ln_slot;
		logic [COL_W-1:0]  col;
		logic [SLOT_W-1:0] rec_slot;
	} rd_req_t;

	typedef struct packed {
		logic [7:0]        pix;
		logic [SLOT_W-1:0] row_slot;
		logic [COL_W-1:0]  col;
		logic              row_zero;
		logic              sub_old;
		logic              col_zero;
		logic              sub_rec;
	} wr_ctl_t;

endpackage

[design/adws_sums.sv]
// Line store, column sums and running window sum for one pixel stage.
`timescale 1ns / 1ps

module adws_sums (
	input  logic                        clk,
	input  logic                        rd_en,
	input  adws_pkg::rd_req_t           rd_req,
	input  logic                        wr_en,
	input  adws_pkg::wr_ctl_t           wr_ctl,
	output logic [adws_pkg::WS_W-1:0]   ws_new
);

	logic [7:0]                  ln_mem  [0:(1 << adws_pkg::LN_AW)-1];
	logic [adws_pkg::CS_W-1:0]   cs_mem  [0:adws_pkg::MAX_COLS-1];
	logic [adws_pkg::CS_W-1:0]   rec_mem [0:adws_pkg::MAX_WIN-1];

	logic [7:0]                  ln_rd_q;
	logic [adws_pkg::CS_W-1:0]   cs_rd_q;
	logic [adws_pkg::CS_W-1:0]   rec_rd_q;
	logic [adws_pkg::WS_W-1:0]   ws_q;
	logic [adws_pkg::CS_W-1:0]   cs_new;
	logic [adws_pkg::LN_AW-1:0]  ln_raddr;
	logic [adws_pkg::LN_AW-1:0]  ln_waddr;
	logic [adws_pkg::SLOT_W-1:0] rec_waddr;

	assign ln_raddr  = {rd_req.ln_slot, rd_req.col};
	assign ln_waddr  = {wr_ctl.row_slot, wr_ctl.col};
	assign rec_waddr = wr_ctl.col[adws_pkg::SLOT_W-1:0];

	// column sum: add the new pixel, drop the one leaving the window height
	assign cs_new = (wr_ctl.row_zero ? '0 : cs_rd_q) + {6'b0, wr_ctl.pix}
		- (wr_ctl.sub_old ? {6'b0, ln_rd_q} : '0);
	assign ws_new = (wr_ctl.col_zero ? '0 : ws_q) + {6'b0, cs_new}
		- (wr_ctl.sub_rec ? {6'b0, rec_rd_q} : '0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ln_mem[ln_waddr]    <= wr_ctl.pix;
			cs_mem[wr_ctl.col]  <= cs_new;
			rec_mem[rec_waddr]  <= cs_new;
			ws_q                <= ws_new;
		end
		// bypass the beat written at this same edge
		if (rd_en) begin
			ln_rd_q  <= (wr_en && ln_waddr == ln_raddr) ? wr_ctl.pix : ln_mem[ln_raddr];
			cs_rd_q  <= (wr_en && wr_ctl.col == rd_req.col) ? cs_new : cs_mem[rd_req.col];
			rec_rd_q <= (wr_en && rec_waddr == rd_req.rec_slot) ? cs_new
				: rec_mem[rd_req.rec_slot];
		end
	end

endmodule

[design/adaptive_dark_window_selector.sv]
// Top level of the adaptive dark window selector.
//
// Pixels enter in raster order on in_valid/in_ready, one beat per pixel;
// frame_start forces the beat to row 0, column 0. Each selected window
// yields one result beat (centre, selection index, ratio in force); the
// last pixel of a frame adds a total beat. last marks the final result
// beat of a pixel. Registers are written on cfg_valid (cfg_ready is
// always high) and take effect at the next frame beginning.
// Throughput: one pixel per cycle while out_ready keeps up; a pixel with two
// results fills both output pair entries, which can stall input.
// The pipeline is input/read stage, sum stage, ratio/compare stage, then
// a two-entry output register. A stall on out_ready backs up through the
// stages and drops in_ready once they are full; nothing is lost.
// Reset clears counters, ratio (94), count and valid flags; registers
// return to 512 x 512, 32 x 32 windows, stride 8. Store contents are
// undefined after reset and are never read before being written.
`timescale 1ns / 1ps

module adaptive_dark_window_selector (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  adws_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output adws_pkg::out_t                  out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [2:0]                      cfg_index,
	input  logic [12:0]                     cfg_data
);

	// configuration
	logic [adws_pkg::NROWS_W-1:0] cfg_rows_q;
	logic [adws_pkg::NCOLS_W-1:0] cfg_cols_q;
	logic [adws_pkg::WIN_W-1:0]   cfg_w_q, cfg_h_q, cfg_stride_q;

	// per-frame latched values
	logic [adws_pkg::NROWS_W-1:0] rows_q;
	logic [adws_pkg::NCOLS_W-1:0] cols_q;
	logic [adws_pkg::WIN_W-1:0]   w_q, h_q, stride_q;
	logic [adws_pkg::AREA_W-1:0]  area_q;

	logic [adws_pkg::ROW_W-1:0]   row_q;
	logic [adws_pkg::COL_W-1:0]   col_q;
	logic [adws_pkg::WIN_W-1:0]   rmod_q, cmod_q;

	logic accept, s1_go, s2_go;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_rows_q   <= 13'd512;
			cfg_cols_q   <= 11'd512;
			cfg_w_q      <= 7'd32;
			cfg_h_q      <= 7'd32;
			cfg_stride_q <= 7'd8;
		end else if (cfg_valid) begin
			case (adws_pkg::cfg_reg_t'(cfg_index))
				adws_pkg::REG_ROWS:   cfg_rows_q   <= cfg_data;
				adws_pkg::REG_COLS:   cfg_cols_q   <= cfg_data[10:0];
				adws_pkg::REG_WIN_W:  cfg_w_q      <= cfg_data[6:0];
				adws_pkg::REG_WIN_H:  cfg_h_q      <= cfg_data[6:0];
				adws_pkg::REG_STRIDE: cfg_stride_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// ---------------- input stage ----------------
	logic [adws_pkg::ROW_W-1:0]   cur_row;
	logic [adws_pkg::COL_W-1:0]   cur_col;
	logic [adws_pkg::WIN_W-1:0]   cur_rmod, cur_cmod;
	logic                         frame_begin;
	logic [adws_pkg::NROWS_W-1:0] cl_rows, e_rows;
	logic [adws_pkg::NCOLS_W-1:0] cl_cols, e_cols;
	logic [adws_pkg::WIN_W-1:0]   cl_w, cl_h, cl_stride, e_w, e_h, e_stride;
	logic [12:0]                  cl_a;
	logic [20:0]                  cl_a255;
	logic [adws_pkg::AREA_W-1:0]  e_area;
	logic [adws_pkg::NROWS_W-1:0] row1;
	logic [adws_pkg::NCOLS_W-1:0] col1;
	logic                         h_fit, w_fit, win_row, win_hit, adapt_hit;
	logic                         end_col, end_frame;
	logic [adws_pkg::NROWS_W-1:0] r_full, cy_full;
	logic [adws_pkg::NCOLS_W-1:0] cx_full;
	logic [adws_pkg::ROW_W-1:0]   ln_diff;
	logic [adws_pkg::COL_W-1:0]   rec_diff;
	adws_pkg::rd_req_t            rd_req;
	adws_pkg::wr_ctl_t            wr_ctl_in;
	logic [adws_pkg::ROW_W-1:0]   row_n;
	logic [adws_pkg::COL_W-1:0]   col_n;
	logic [adws_pkg::WIN_W-1:0]   rmod_n, cmod_n;

	always_comb begin
		cur_row     = in_data.frame_start ? '0 : row_q;
		cur_col     = in_data.frame_start ? '0 : col_q;
		cur_rmod    = in_data.frame_start ? '0 : rmod_q;
		cur_cmod    = in_data.frame_start ? '0 : cmod_q;
		frame_begin = (cur_row == '0) && (cur_col == '0);

		cl_rows   = (cfg_rows_q == '0) ? 13'd1
			: (cfg_rows_q > 13'(adws_pkg::MAX_ROWS)) ? 13'(adws_pkg::MAX_ROWS) : cfg_rows_q;
		cl_cols   = (cfg_cols_q == '0) ? 11'd1
			: (cfg_cols_q > 11'(adws_pkg::MAX_COLS)) ? 11'(adws_pkg::MAX_COLS) : cfg_cols_q;
		cl_w      = (cfg_w_q == '0) ? 7'd1
			: (cfg_w_q > 7'(adws_pkg::MAX_WIN)) ? 7'(adws_pkg::MAX_WIN) : cfg_w_q;
		cl_h      = (cfg_h_q == '0) ? 7'd1
			: (cfg_h_q > 7'(adws_pkg::MAX_WIN)) ? 7'(adws_pkg::MAX_WIN) : cfg_h_q;
		cl_stride = (cfg_stride_q == '0) ? 7'd1 : cfg_stride_q;
		cl_a      = {6'b0, cl_w} * {6'b0, cl_h};
		cl_a255   = {cl_a, 8'b0} - {8'b0, cl_a};

		e_rows   = frame_begin ? cl_rows : rows_q;
		e_cols   = frame_begin ? cl_cols : cols_q;
		e_w      = frame_begin ? cl_w : w_q;
		e_h      = frame_begin ? cl_h : h_q;
		e_stride = frame_begin ? cl_stride : stride_q;
		e_area   = frame_begin ? cl_a255[adws_pkg::AREA_W-1:0] : area_q;

		row1      = {1'b0, cur_row} + 13'd1;
		col1      = {1'b0, cur_col} + 11'd1;
		h_fit     = row1 >= {6'b0, e_h};
		w_fit     = col1 >= {4'b0, e_w};
		win_row   = h_fit && (cur_rmod == '0);
		win_hit   = win_row && w_fit && (cur_cmod == '0);
		adapt_hit = win_row && (cur_col == '0);
		end_col   = col1 >= e_cols;
		end_frame = end_col && (row1 >= e_rows);

		r_full  = row1 - {6'b0, e_h};
		cy_full = r_full + {7'b0, e_h[6:1]};
		cx_full = col1 - {4'b0, e_w} + {5'b0, e_w[6:1]};

		ln_diff  = cur_row - {5'b0, e_h};
		rec_diff = cur_col - {3'b0, e_w};
		rd_req.ln_slot  = ln_diff[adws_pkg::SLOT_W-1:0];
		rd_req.col      = cur_col;
		rd_req.rec_slot = rec_diff[adws_pkg::SLOT_W-1:0];

		wr_ctl_in.pix      = in_data.pixel;
		wr_ctl_in.row_slot = cur_row[adws_pkg::SLOT_W-1:0];
		wr_ctl_in.col      = cur_col;
		wr_ctl_in.row_zero = cur_row == '0;
		wr_ctl_in.sub_old  = cur_row >= {5'b0, e_h};
		wr_ctl_in.col_zero = cur_col == '0;
		wr_ctl_in.sub_rec  = cur_col >= {3'b0, e_w};

		// advance raster position and stride phases
		if (end_col) begin
			col_n  = '0;
			cmod_n = '0;
			row_n  = end_frame ? '0 : row1[adws_pkg::ROW_W-1:0];
			if (end_frame || row1 < {6'b0, e_h})
				rmod_n = '0;
			else
				rmod_n = (cur_rmod + 7'd1 == e_stride) ? '0 : cur_rmod + 7'd1;
		end else begin
			col_n  = col1[adws_pkg::COL_W-1:0];
			row_n  = cur_row;
			rmod_n = cur_rmod;
			if (col1 < {4'b0, e_w})
				cmod_n = '0;
			else
				cmod_n = (cur_cmod + 7'd1 == e_stride) ? '0 : cur_cmod + 7'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			rmod_q   <= '0;
			cmod_q   <= '0;
			rows_q   <= 13'd512;
			cols_q   <= 11'd512;
			w_q      <= 7'd32;
			h_q      <= 7'd32;
			stride_q <= 7'd8;
			area_q   <= 20'd261120;
		end else if (accept) begin
			row_q    <= row_n;
			col_q    <= col_n;
			rmod_q   <= rmod_n;
			cmod_q   <= cmod_n;
			rows_q   <= e_rows;
			cols_q   <= e_cols;
			w_q      <= e_w;
			h_q      <= e_h;
			stride_q <= e_stride;
			area_q   <= e_area;
		end
	end

	// ---------------- sum stage ----------------
	logic                         s1_v;
	adws_pkg::wr_ctl_t            wr_ctl_s1;
	logic                         begin_s1, adapt_s1, win_s1, end_s1;
	logic [adws_pkg::ROW_W-1:0]   r_s1;
	logic [adws_pkg::NROWS_W-1:0] rows_s1;
	logic [10:0]                  cx_s1;
	logic [12:0]                  cy_s1;
	logic [adws_pkg::AREA_W-1:0]  area_s1;
	logic [adws_pkg::WS_W-1:0]    ws_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_v <= 1'b0;
		else if (accept)
			s1_v <= 1'b1;
		else if (s1_go)
			s1_v <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_ctl_s1 <= wr_ctl_in;
			begin_s1  <= frame_begin;
			adapt_s1  <= adapt_hit;
			win_s1    <= win_hit;
			end_s1    <= end_frame;
			r_s1      <= r_full[adws_pkg::ROW_W-1:0];
			rows_s1   <= e_rows;
			cx_s1     <= cx_full;
			cy_s1     <= cy_full;
			area_s1   <= e_area;
		end
	end

	adws_sums u_sums (
		.clk    (clk),
		.rd_en  (accept),
		.rd_req (rd_req),
		.wr_en  (s1_go),
		.wr_ctl (wr_ctl_s1),
		.ws_new (ws_new)
	);

	logic [14:0] r4, r3, r2, rows3;
	logic        q4_s1, q2_s1, q3_s1;
	logic [adws_pkg::THR_W-1:0] ws100;

	always_comb begin
		r4    = {1'b0, r_s1, 2'b0};
		r3    = {3'b0, r_s1} + {2'b0, r_s1, 1'b0};
		r2    = {2'b0, r_s1, 1'b0};
		rows3 = {2'b0, rows_s1} + {1'b0, rows_s1, 1'b0};
		q4_s1 = r4 > rows3;
		q2_s1 = r2 > {2'b0, rows_s1};
		q3_s1 = r3 > {2'b0, rows_s1};
		ws100 = {1'b0, ws_new, 6'b0} + {2'b0, ws_new, 5'b0} + {5'b0, ws_new, 2'b0};
	end

	// ---------------- ratio / compare stage ----------------
	logic                         s2_v;
	logic                         begin_s2, adapt_s2, win_s2, end_s2;
	logic                         q4_s2, q2_s2, q3_s2;
	logic [adws_pkg::THR_W-1:0]   ws100_s2;
	logic [10:0]                  cx_s2;
	logic [12:0]                  cy_s2;
	logic [adws_pkg::AREA_W-1:0]  area_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_v <= 1'b0;
		else if (s1_go)
			s2_v <= 1'b1;
		else if (s2_go)
			s2_v <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			begin_s2 <= begin_s1;
			adapt_s2 <= adapt_s1;
			win_s2   <= win_s1;
			end_s2   <= end_s1;
			q4_s2    <= q4_s1;
			q2_s2    <= q2_s1;
			q3_s2    <= q3_s1;
			ws100_s2 <= ws100;
			cx_s2    <= cx_s1;
			cy_s2    <= cy_s1;
			area_s2  <= area_s1;
		end
	end

	logic [adws_pkg::RATIO_W-1:0] ratio_q, ratio_base, ratio_new;
	logic [adws_pkg::RATIO_W-1:0] ratio_up, ratio_dn10, ratio_dn20;
	logic [adws_pkg::CNT_W-1:0]   cnt_q, cnt_base, cnt_new;
	logic [adws_pkg::THR_W-1:0]   thr;
	logic                         sel;
	adws_pkg::out_t               sel_res, tot_res;

	always_comb begin
		ratio_base = begin_s2 ? adws_pkg::RATIO_START : ratio_q;
		cnt_base   = begin_s2 ? '0 : cnt_q;
		// compare before adding so the 7-bit sum cannot wrap
		ratio_up   = (ratio_base > adws_pkg::RATIO_CAP - 7'd30) ? adws_pkg::RATIO_CAP
			: ratio_base + 7'd30;
		ratio_dn10 = (ratio_base < adws_pkg::RATIO_FLOOR + 7'd10) ? adws_pkg::RATIO_FLOOR
			: ratio_base - 7'd10;
		ratio_dn20 = (ratio_base < adws_pkg::RATIO_FLOOR + 7'd20) ? adws_pkg::RATIO_FLOOR
			: ratio_base - 7'd20;
		ratio_new = ratio_base;
		if (adapt_s2) begin
			if (q4_s2) begin
				if (cnt_base < 23'd1000)      ratio_new = ratio_up;
				else if (cnt_base > 23'd7000) ratio_new = ratio_dn20;
			end else if (q2_s2) begin
				if (cnt_base < 23'd1000)      ratio_new = ratio_up;
				else if (cnt_base > 23'd4000) ratio_new = ratio_dn10;
			end else if (q3_s2) begin
				if (cnt_base < 23'd600)       ratio_new = ratio_up;
				else if (cnt_base > 23'd2000) ratio_new = ratio_dn10;
			end
		end
		thr = {7'b0, area_s2} * {20'b0, ratio_new};
		sel = win_s2 && (ws100_s2 < thr);
		cnt_new = (sel && cnt_base != adws_pkg::COUNT_MAX) ? cnt_base + 23'd1 : cnt_base;

		sel_res.kind      = 1'b0;
		sel_res.centre_x  = cx_s2;
		sel_res.centre_y  = cy_s2;
		sel_res.count     = cnt_base;
		sel_res.ratio_pct = ratio_new;
		sel_res.last      = !end_s2;

		tot_res.kind      = 1'b1;
		tot_res.centre_x  = '0;
		tot_res.centre_y  = '0;
		tot_res.count     = cnt_new;
		tot_res.ratio_pct = ratio_new;
		tot_res.last      = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= adws_pkg::RATIO_START;
			cnt_q   <= '0;
		end else if (s2_go) begin
			ratio_q <= ratio_new;
			cnt_q   <= cnt_new;
		end
	end

	// ---------------- output pair register ----------------
	logic           a_v_q, b_v_q, out_fire, can_load, has_res;
	adws_pkg::out_t a_q, b_q;

	assign out_fire = a_v_q && out_ready;
	assign can_load = !a_v_q || (out_fire && !b_v_q);
	assign has_res  = sel || end_s2;
	assign s2_go    = s2_v && (!has_res || can_load);
	assign s1_go    = s1_v && (!s2_v || s2_go);
	assign in_ready = !s1_v || s1_go;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_v_q <= 1'b0;
			b_v_q <= 1'b0;
		end else if (s2_go && has_res) begin
			a_v_q <= 1'b1;
			b_v_q <= sel && end_s2;
		end else if (out_fire) begin
			// advance the second beat
			a_v_q <= b_v_q;
			b_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && has_res) begin
			a_q <= sel ? sel_res : tot_res;
			b_q <= tot_res;
		end else if (out_fire) begin
			a_q <= b_q;
		end
	end

	assign out_valid = a_v_q;
	assign out_data  = a_q;

	// ---------------- assertions ----------------
	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		ratio_q >= adws_pkg::RATIO_FLOOR && ratio_q <= adws_pkg::RATIO_CAP)
		else $error("ratio left its range");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		b_v_q |-> a_v_q)
		else $error("second result held without a first");

	a_second_is_total: assert property (@(posedge clk) disable iff (!arst_n)
		b_v_q |-> (b_q.kind && b_q.last && !a_q.last))
		else $error("second result is not a closing total");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_v)
		else $error("accepted pixel lost from sum stage");

endmodule

[tb/sv/adws_checker.sv]
// Predicting checker for the adaptive dark window selector: tracks pixels and register writes.
`timescale 1ns / 1ps

module adws_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  adws_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  adws_pkg::out_t out_data,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [12:0]    cfg_data,
	output int             fail_count,
	output int             reports_waiting
);

	logic [7:0]     line_mem [0:adws_pkg::MAX_WIN*adws_pkg::MAX_COLS-1];
	int unsigned    col_sum [0:adws_pkg::MAX_COLS-1];
	int unsigned    row_ctr, col_ctr, ratio, threshold, sel_count;
	int unsigned    reg_rows, reg_cols, reg_w, reg_h, reg_stride;
	int unsigned    f_rows, f_cols, f_w, f_h, f_stride;
	adws_pkg::out_t report_q[$];

	function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	task automatic note_mismatch(string what, int unsigned got, int unsigned want);
		$display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic step_ratio(int unsigned r);
		int unsigned up_lim, down_lim, down_by;
		up_lim = 0;
		down_lim = 0;
		down_by = 0;
		if (4 * r > 3 * f_rows) begin
			up_lim = 1000; down_lim = 7000; down_by = 20;
		end else if (2 * r > f_rows) begin
			up_lim = 1000; down_lim = 4000; down_by = 10;
		end else if (3 * r > f_rows) begin
			up_lim = 600; down_lim = 2000; down_by = 10;
		end
		if (down_by != 0) begin
			if (sel_count < up_lim)
				ratio = (ratio + 30 > adws_pkg::RATIO_CAP) ? adws_pkg::RATIO_CAP : ratio + 30;
			else if (sel_count > down_lim)
				ratio = (ratio < adws_pkg::RATIO_FLOOR + down_by) ? adws_pkg::RATIO_FLOOR
					: ratio - down_by;
		end
		threshold = f_w * f_h * 255 * ratio;
	endtask

	task automatic track_pixel(adws_pkg::in_t d);
		int unsigned row, col, k, sum, r, c, wsum;
		adws_pkg::out_t reps[2];
		int nrep;
		nrep = 0;
		if (d.frame_start) begin
			row_ctr = 0;
			col_ctr = 0;
		end
		if (row_ctr == 0 && col_ctr == 0) begin
			f_rows = clip(reg_rows, 1, adws_pkg::MAX_ROWS);
			f_cols = clip(reg_cols, 1, adws_pkg::MAX_COLS);
			f_w = clip(reg_w, 1, adws_pkg::MAX_WIN);
			f_h = clip(reg_h, 1, adws_pkg::MAX_WIN);
			f_stride = reg_stride == 0 ? 1 : reg_stride;
			ratio = adws_pkg::RATIO_START;
			sel_count = 0;
			threshold = f_w * f_h * 255 * ratio;
		end
		if (row_ctr >= f_rows) row_ctr = 0;
		if (col_ctr >= f_cols) col_ctr = 0;
		row = row_ctr;
		col = col_ctr;
		line_mem[(row % adws_pkg::MAX_WIN) * adws_pkg::MAX_COLS + col] = d.pixel;
		sum = 0;
		for (k = 0; k < f_h && k <= row; k++)
			sum += line_mem[((row - k) % adws_pkg::MAX_WIN) * adws_pkg::MAX_COLS + col];
		col_sum[col] = sum;
		if (row + 1 >= f_h) begin
			r = row + 1 - f_h;
			if (r % f_stride == 0) begin
				if (col == 0) step_ratio(r);
				if (col + 1 >= f_w) begin
					c = col + 1 - f_w;
					if (c % f_stride == 0) begin
						wsum = 0;
						for (k = 0; k < f_w; k++) wsum += col_sum[col - k];
						if (wsum * 100 < threshold) begin
							reps[nrep].kind      = 1'b0;
							reps[nrep].centre_x  = 11'(c + f_w / 2);
							reps[nrep].centre_y  = 13'(r + f_h / 2);
							reps[nrep].count     = sel_count[adws_pkg::CNT_W-1:0];
							reps[nrep].ratio_pct = ratio[adws_pkg::RATIO_W-1:0];
							reps[nrep].last      = 1'b0;
							nrep++;
							if (sel_count < adws_pkg::COUNT_MAX) sel_count++;
						end
					end
				end
			end
		end
		col_ctr = col + 1;
		if (col_ctr >= f_cols) begin
			col_ctr = 0;
			row_ctr = row + 1;
			if (row_ctr >= f_rows) begin
				row_ctr = 0;
				reps[nrep].kind      = 1'b1;
				reps[nrep].centre_x  = '0;
				reps[nrep].centre_y  = '0;
				reps[nrep].count     = sel_count[adws_pkg::CNT_W-1:0];
				reps[nrep].ratio_pct = ratio[adws_pkg::RATIO_W-1:0];
				reps[nrep].last      = 1'b0;
				nrep++;
			end
		end
		if (nrep > 0) reps[nrep-1].last = 1'b1;
		for (int i = 0; i < nrep; i++) report_q = {report_q, reps[i]};
	endtask

	task automatic check_report(adws_pkg::out_t got);
		adws_pkg::out_t want;
		if (report_q.size() == 0) begin
			note_mismatch("unexpected result beat", 0, 0);
			return;
		end
		want = report_q.pop_front();
		if (got.kind !== want.kind)
			note_mismatch("kind", 32'(got.kind), 32'(want.kind));
		if (got.centre_x !== want.centre_x)
			note_mismatch("centre_x", 32'(got.centre_x), 32'(want.centre_x));
		if (got.centre_y !== want.centre_y)
			note_mismatch("centre_y", 32'(got.centre_y), 32'(want.centre_y));
		if (got.count !== want.count)
			note_mismatch("count", 32'(got.count), 32'(want.count));
		if (got.ratio_pct !== want.ratio_pct)
			note_mismatch("ratio_pct", 32'(got.ratio_pct), 32'(want.ratio_pct));
		if (got.last !== want.last)
			note_mismatch("last", 32'(got.last), 32'(want.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ctr = 0; col_ctr = 0; ratio = adws_pkg::RATIO_START; threshold = 0;
			sel_count = 0;
			reg_rows = 512; reg_cols = 512; reg_w = 32; reg_h = 32; reg_stride = 8;
			f_rows = 512; f_cols = 512; f_w = 32; f_h = 32; f_stride = 8;
			report_q.delete();
			fail_count = 0;
			reports_waiting = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (adws_pkg::cfg_reg_t'(cfg_index))
					adws_pkg::REG_ROWS:   reg_rows = 32'(cfg_data[12:0]);
					adws_pkg::REG_COLS:   reg_cols = 32'(cfg_data[10:0]);
					adws_pkg::REG_WIN_W:  reg_w = 32'(cfg_data[6:0]);
					adws_pkg::REG_WIN_H:  reg_h = 32'(cfg_data[6:0]);
					adws_pkg::REG_STRIDE: reg_stride = 32'(cfg_data[6:0]);
					default: ;
				endcase
			end
			if (in_valid && in_ready) track_pixel(in_data);
			if (out_valid && out_ready) check_report(out_data);
			reports_waiting = report_q.size();
		end
	end

endmodule

[tb/sv/adaptive_dark_window_selector_tb.sv]
// Testbench top for the adaptive dark window selector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module adaptive_dark_window_selector_tb;

	localparam int CYCLE_LIMIT = 400000;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_ready;
	adws_pkg::in_t  in_data = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	adws_pkg::out_t out_data;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [2:0]     cfg_index = '0;
	logic [12:0]    cfg_data = '0;
	int             fail_count;
	int             reports_waiting;
	int             pixels_sent = 0;
	int             cycles = 0;
	bit             idle_on = 1'b1;
	bit             hold_req = 1'b0;

	always #5 clk = ~clk;

	adaptive_dark_window_selector u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	adws_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .reports_waiting(reports_waiting)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: random stall bursts, plus one long hold when asked.
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (300) @(negedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat.
	task automatic send_pixel(logic [7:0] pix, logic fs);
		adws_pkg::in_t d;
		d.pixel = pix;
		d.frame_start = fs;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_data = d;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic drain;
		in_valid = 1'b0;
		while (reports_waiting != 0) @(negedge clk);
		// pixels without results may still be in flight
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(adws_pkg::cfg_reg_t idx, logic [12:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic setup(int rows, int cols, int w, int h, int stride);
		drain();
		write_reg(adws_pkg::REG_ROWS, 13'(rows));
		write_reg(adws_pkg::REG_COLS, 13'(cols));
		write_reg(adws_pkg::REG_WIN_W, 13'(w));
		write_reg(adws_pkg::REG_WIN_H, 13'(h));
		write_reg(adws_pkg::REG_STRIDE, 13'(stride));
	endtask

	function automatic logic [7:0] shade(int mode);
		case (mode)
			0: return 8'($urandom_range(0, 255));
			1: return 8'($urandom_range(200, 255));
			2: return 8'($urandom_range(0, 40));
			default: return 8'($urandom_range(230, 255));
		endcase
	endfunction

	initial begin
		int rows, cols, n, mode;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// defaults, partial frame
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		// tiny full frame, then a frame that begins without the marker
		setup(4, 4, 2, 2, 1);
		for (int i = 0; i < 20; i++)
			send_pixel(i % 3 == 0 ? 8'd255 : 8'd0, i == 0);
		// window larger than the image
		setup(3, 3, 5, 5, 1);
		for (int i = 0; i < 9; i++) send_pixel(8'd0, i == 0);
		// zero registers clamp to a 1 x 1 image
		setup(0, 0, 0, 0, 0);
		for (int i = 0; i < 3; i++) send_pixel(i == 1 ? 8'd255 : 8'd0, 1'b0);
		// over-range size and window, then the largest legal size and window
		setup(8191, 2047, 127, 127, 127);
		for (int i = 0; i < 3; i++) send_pixel(8'd7, i == 0);
		setup(4096, 1024, 64, 64, 64);
		for (int i = 0; i < 3; i++) send_pixel(8'd128, i == 0);

		for (int phase = 0; pixels_sent < 620; phase++) begin
			if (pixels_sent > 520) idle_on = 1'b0;
			rows = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
			cols = $urandom_range(1, 16);
			setup(rows, cols, $urandom_range(1, 6), $urandom_range(1, 6),
				$urandom_range(1, 3));
			if (phase == 2) hold_req = 1'b1;
			n = rows * cols * $urandom_range(1, 2) + $urandom_range(0, 3);
			if (n > 90) n = 90;
			mode = $urandom_range(0, 3);
			for (int i = 0; i < n; i++)
				send_pixel(shade(mode), i == 0 || $urandom_range(0, 59) == 0);
		end

		drain();
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
